// ===== rtl/spq_pkg.sv =====
package spq_pkg;

    localparam int ENTRY_W = 5;
    localparam int PRI_W   = 8;
    localparam int TAG_W   = 16;
    localparam int OP_W    = 2;
    localparam int STS_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_RD,
        S_EV,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start;   // capture the input beat
        logic read;    // issue a slot read
        logic eval;    // act on the slot just read
        logic finish;  // load the result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic quick;   // no scan needed
        logic last;    // scan ends with this eval
    } t_dp_sts;

endpackage

// ===== rtl/sorted_priority_queue.sv =====
// Channel  | Direction | Handshake                  | Beat contents
// ---------+-----------+----------------------------+------------------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_op, i_key_priority, i_payload_tag
// out      | output    | o_out_valid / i_out_ready  | o_status, o_out_priority, o_out_tag,
//          |           |                            | o_entry_count, o_is_empty
//
// Sequencing: one operation at a time. No-op, full insert and empty pop/remove go from
//   acceptance through S_PREP straight to the result register. Insert visits k+1 slots, k being the
//   entries of lower priority it passes; pop and remove visit all N held entries.
//   Each visited slot is read (S_RD) and then evaluated (S_EV) on the single slot memory.
// Reset: synchronous, active low; clears the held count, state and result valid.
// Stalls: a finished result sits in the output register while the next beat is taken.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [OP_W-1:0]    i_op,
    input  logic [PRI_W-1:0]   i_key_priority,
    input  logic [TAG_W-1:0]   i_payload_tag,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [STS_W-1:0]   o_status,
    output logic [PRI_W-1:0]   o_out_priority,
    output logic [TAG_W-1:0]   o_out_tag,
    output logic [ENTRY_W-1:0] o_entry_count,
    output logic               o_is_empty
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: accept, prepare, read/evaluate loop, deliver
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // slot memory, scan index, count and result register
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_op           (i_op),
        .i_key_priority (i_key_priority),
        .i_payload_tag  (i_payload_tag),
        .o_status       (o_status),
        .o_out_priority (o_out_priority),
        .o_out_tag      (o_out_tag),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty)
    );

endmodule

// ===== rtl/spq_ctrl.sv =====
module spq_ctrl
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_PREP;
                end
            end
            S_PREP: begin
                n_state = i_sts.quick ? S_DONE : S_RD;
            end
            S_RD: begin
                o_cmd.read = 1'b1;
                n_state    = S_EV;
            end
            S_EV: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.last ? S_DONE : S_RD;
            end
            S_DONE: begin
                // result register free, or drained this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/spq_datapath.sv =====
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [OP_W-1:0]    i_op,
    input  logic [PRI_W-1:0]   i_key_priority,
    input  logic [TAG_W-1:0]   i_payload_tag,
    output logic [STS_W-1:0]   o_status,
    output logic [PRI_W-1:0]   o_out_priority,
    output logic [TAG_W-1:0]   o_out_tag,
    output logic [ENTRY_W-1:0] o_entry_count,
    output logic               o_is_empty
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // slot store, sorted highest first
    logic [PRI_W-1:0]   r_mem_pri [DEPTH];
    logic [TAG_W-1:0]   r_mem_tag [DEPTH];

    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_found, n_found;
    t_op                r_op;
    logic [PRI_W-1:0]   r_key;
    logic [TAG_W-1:0]   r_tag;
    t_status            r_status, n_status;
    logic [PRI_W-1:0]   r_opri, n_opri;
    logic [TAG_W-1:0]   r_otag, n_otag;
    logic [PRI_W-1:0]   r_rd_pri;
    logic [TAG_W-1:0]   r_rd_tag;

    logic [STS_W-1:0]   r_o_status;
    logic [PRI_W-1:0]   r_o_pri;
    logic [TAG_W-1:0]   r_o_tag;
    logic [ENTRY_W-1:0] r_o_cnt;
    logic               r_o_empty;

    logic [CNT_W-1:0]   idx_m1;
    logic [ADDR_W-1:0]  rd_addr;
    logic               we;
    logic [ADDR_W-1:0]  wr_addr;
    logic [PRI_W-1:0]   wr_pri;
    logic [TAG_W-1:0]   wr_tag;
    logic               shift;
    logic               match;
    logic               rm_last;
    t_op                in_op;

    assign in_op  = t_op'(i_op);
    assign idx_m1 = r_idx - 1'b1;

    // insert walks from the rear, pop/remove from the front
    assign rd_addr = (r_op == OP_INSERT) ? idx_m1[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
    assign shift   = (r_idx != '0) && (r_rd_pri < r_key);
    assign match   = (r_op == OP_POP) ? (r_idx == '0) : (r_rd_pri == r_key);
    assign rm_last = (r_idx + 1'b1) == r_count;

    always_comb begin
        o_sts.quick = (r_op == OP_NOP) || (r_status != ST_OK);
        o_sts.last  = (r_op == OP_INSERT) ? !shift : rm_last;
    end

    always_comb begin
        n_count  = r_count;
        n_idx    = r_idx;
        n_found  = r_found;
        n_status = r_status;
        n_opri   = r_opri;
        n_otag   = r_otag;
        we       = 1'b0;
        wr_addr  = r_idx[ADDR_W-1:0];
        wr_pri   = r_key;
        wr_tag   = r_tag;
        if (i_cmd.start) begin
            n_idx   = (in_op == OP_INSERT) ? r_count : '0;
            n_found = 1'b0;
            n_opri  = '0;
            n_otag  = '0;
            case (in_op)
                OP_INSERT: n_status = (r_count == CNT_W'(DEPTH)) ? ST_FULL : ST_OK;
                OP_POP,
                OP_REMOVE: n_status = (r_count == '0) ? ST_EMPTY : ST_OK;
                default:   n_status = ST_OK;
            endcase
        end else if (i_cmd.eval) begin
            if (r_op == OP_INSERT) begin
                we = 1'b1;
                if (shift) begin
                    wr_pri = r_rd_pri;
                    wr_tag = r_rd_tag;
                    n_idx  = idx_m1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end else begin
                // close the gap behind the taken entry
                we      = r_found;
                wr_addr = idx_m1[ADDR_W-1:0];
                wr_pri  = r_rd_pri;
                wr_tag  = r_rd_tag;
                n_idx   = r_idx + 1'b1;
                if (!r_found && match) begin
                    n_found = 1'b1;
                    n_opri  = r_rd_pri;
                    n_otag  = r_rd_tag;
                end
                if (rm_last) begin
                    if (r_found || match) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        n_status = ST_NOTFOUND;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_pri[wr_addr] <= wr_pri;
            r_mem_tag[wr_addr] <= wr_tag;
        end
        if (i_cmd.read) begin
            r_rd_pri <= r_mem_pri[rd_addr];
            r_rd_tag <= r_mem_tag[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= in_op;
            r_key <= i_key_priority;
            r_tag <= i_payload_tag;
        end
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_status <= n_status;
        r_opri   <= n_opri;
        r_otag   <= n_otag;
        if (i_cmd.finish) begin
            r_o_status <= r_status;
            r_o_pri    <= r_opri;
            r_o_tag    <= r_otag;
            r_o_cnt    <= ENTRY_W'(r_count);
            r_o_empty  <= (r_count == '0);
        end
    end

    assign o_status       = r_o_status;
    assign o_out_priority = r_o_pri;
    assign o_out_tag      = r_o_tag;
    assign o_entry_count  = r_o_cnt;
    assign o_is_empty     = r_o_empty;

endmodule

// ===== rtl/spq_checker.sv =====
module spq_checker
    import spq_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [STS_W-1:0]   o_status,
    input logic [PRI_W-1:0]   o_out_priority,
    input logic [TAG_W-1:0]   o_out_tag,
    input logic [ENTRY_W-1:0] o_entry_count,
    input logic               o_is_empty
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_out_priority) && $stable(o_out_tag)
            && $stable(o_entry_count) && $stable(o_is_empty))
        else $error("stalled result changed");

    a_fail_zero_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_out_priority == '0) && (o_out_tag == '0))
        else $error("failed operation reports an entry");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> (o_entry_count == '0))
        else $error("empty flag with nonzero count");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> o_is_empty)
        else $error("empty status on a nonempty queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
